FILE: rtl/sequence_statistics_anomaly_flag_defines.svh
// Assertion macros shared by the checker of the sequence statistics block.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef SEQUENCE_STATISTICS_ANOMALY_FLAG_DEFINES_SVH
`define SEQUENCE_STATISTICS_ANOMALY_FLAG_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SSAF_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssaf check failed");

// Next-cycle implication, checked outside reset
`define SSAF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssaf check failed");

`endif

FILE: rtl/ssaf_pkg.sv
// Shared types and constants of the sequence statistics block.
// No dependencies.
package ssaf_pkg;
	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIVERGENCE_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CALM_MEAN_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOLATILE_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_DIVISOR    = 3'd4;

	localparam logic [10:0] RST_BASELINE_LENGTH  = 11'd0;
	localparam logic [15:0] RST_DIVERGENCE_LIMIT = 16'd4915;
	localparam logic [15:0] RST_CALM_MEAN_LIMIT  = 16'd2458;
	localparam logic [31:0] RST_VOLATILE_LIMIT   = 32'd26843546;
	localparam logic [7:0]  RST_SPIKE_DIVISOR    = 8'd10;

	typedef struct packed {
		logic [10:0] baseline_length;
		logic [15:0] divergence_limit;
		logic [15:0] calm_mean_limit;
		logic [31:0] volatile_variance_limit;
		logic [7:0]  spike_divisor;
	} cfg_t;
endpackage

FILE: rtl/ssaf_front.sv
// Front end: takes requests, writes the sample store, keeps running sums.
// Depends on ssaf_pkg.
module ssaf_front #(
	parameter int MaxElements = ssaf_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [15:0]                       sample,
	input  logic [15:0]                       baseline_sample,
	input  logic                              last,
	input  logic [10:0]                       baseline_length,
	output logic                              mem_we,
	output logic [$clog2(MaxElements)-1:0]    mem_addr,
	output logic [15:0]                       mem_wdata,
	output logic                              push,
	output logic [$clog2(MaxElements+1)-1:0]  job_n,
	output logic [$clog2(MaxElements+1)+15:0] job_sum,
	output logic [$clog2(MaxElements+1)+31:0] job_bsum
);
	import ssaf_pkg::*;
	localparam int CW = $clog2(MaxElements + 1);
	localparam int AW = $clog2(MaxElements);
	localparam int SW = CW + 16;
	localparam int BW = CW + 32;

	logic [CW-1:0] cnt_q, cnt_nx;
	logic [SW-1:0] sum_q, sum_nx;
	logic [BW-1:0] bsum_q, bsum_nx;
	logic          has_room, in_base;
	logic signed [16:0] diff;
	logic signed [33:0] diff_sq;

	// classify the request: stored, and inside the baseline window
	assign has_room = cnt_q < CW'(MaxElements);
	assign in_base  = 32'(cnt_q) < 32'(baseline_length);
	assign diff     = $signed({1'b0, sample}) - $signed({1'b0, baseline_sample});
	assign diff_sq  = diff * diff;

	always_comb begin
		cnt_nx  = cnt_q;
		sum_nx  = sum_q;
		bsum_nx = bsum_q;
		if (has_room) begin
			cnt_nx = cnt_q + CW'(1);
			sum_nx = sum_q + SW'(sample);
			if (in_base) begin
				bsum_nx = bsum_q + BW'(diff_sq[31:0]);
			end
		end
	end

	// advance the sums; clear them once the sequence ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sum_q  <= '0;
			bsum_q <= '0;
		end else if (accept) begin
			if (last) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				bsum_q <= '0;
			end else begin
				cnt_q  <= cnt_nx;
				sum_q  <= sum_nx;
				bsum_q <= bsum_nx;
			end
		end
	end

	assign mem_we    = accept & has_room;
	assign mem_addr  = cnt_q[AW-1:0];
	assign mem_wdata = sample;
	assign push      = accept & last;
	assign job_n     = cnt_nx;
	assign job_sum   = sum_nx;
	assign job_bsum  = bsum_nx;
endmodule

FILE: rtl/ssaf_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on ssaf_pkg.
module ssaf_queue #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output logic             not_empty
);
	import ssaf_pkg::*;

	logic [Width-1:0] entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;

	// store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign rdata     = entry_q[rd_ptr_q];
	assign not_empty = cnt_q != 2'd0;
endmodule

FILE: rtl/ssaf_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ssaf_pkg.
module ssaf_div #(
	parameter int DW = 43,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);
	import ssaf_pkg::*;
	localparam int KW = $clog2(DW + 1);

	logic          run_q, done_q;
	logic [KW-1:0] cnt_q;
	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q, dvsr_q;
	logic [VW:0]   trial, diff;
	logic          ge;

	// one shift-subtract step
	assign trial = {rem_q, quot_q[DW-1]};
	assign ge    = trial >= {1'b0, dvsr_q};
	assign diff  = ge ? trial - {1'b0, dvsr_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + KW'(1);
				if (cnt_q == KW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= diff[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

FILE: rtl/ssaf_back.sv
// Back end: sample store, one pass over it, shared divider and square root.
// Depends on ssaf_pkg and ssaf_div.
module ssaf_back #(
	parameter int MaxElements = ssaf_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ssaf_pkg::cfg_t                    cfg,
	input  logic                              mem_we,
	input  logic [$clog2(MaxElements)-1:0]    mem_addr,
	input  logic [15:0]                       mem_wdata,
	input  logic                              job_valid,
	input  logic [$clog2(MaxElements+1)-1:0]  job_n,
	input  logic [$clog2(MaxElements+1)+15:0] job_sum,
	input  logic [$clog2(MaxElements+1)+31:0] job_bsum,
	output logic                              job_pop,
	output logic                              active,
	output logic                              done,
	output logic [15:0]                       mean_value,
	output logic [31:0]                       variance_value,
	output logic signed [16:0]                trend_value,
	output logic [9:0]                        spike_count,
	output logic [15:0]                       head_mean,
	output logic [15:0]                       tail_mean,
	output logic [15:0]                       head_tail_gap,
	output logic [15:0]                       rms_distance,
	output logic                              anomaly
);
	import ssaf_pkg::*;
	localparam int CW = $clog2(MaxElements + 1);
	localparam int AW = $clog2(MaxElements);
	localparam int SW = CW + 16;
	localparam int BW = CW + 32;
	// n / 3 as (n * ceil(2^17 / 3)) >> 17, exact for counts below 2^17
	localparam int          THIRD_SHIFT = 17;
	localparam logic [15:0] THIRD_RECIP = 16'd43691;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MEAN  = 4'd1;
	localparam logic [3:0] ST_THIRD = 4'd2;
	localparam logic [3:0] ST_PASS  = 4'd3;
	localparam logic [3:0] ST_VAR   = 4'd4;
	localparam logic [3:0] ST_TREND = 4'd5;
	localparam logic [3:0] ST_HEAD  = 4'd6;
	localparam logic [3:0] ST_TAIL  = 4'd7;
	localparam logic [3:0] ST_DIST  = 4'd8;
	localparam logic [3:0] ST_SQRT  = 4'd9;
	localparam logic [3:0] ST_DONE  = 4'd10;

	logic [15:0] mem [MaxElements];

	logic [3:0]    state_q;
	logic          launched_q;
	logic [CW-1:0] n_q, len_q, t_q, tail_start_q, idx_q, spk_q;
	logic [SW-1:0] sum_q, hs_q, ts_q;
	logic [BW-1:0] bsum_q, acc_q, dq_q;
	logic [31:0]   lim_sq_q, var_q, sv_q, sres_q, sbit_q;
	logic [15:0]   mean_q, first_q, lastx_q, prev_q, head_q, tail_q, dist_q;
	logic signed [16:0] trend_q;
	logic          dr_nz_q;

	// pass pipeline
	logic          rd_en, vld_s1, vld_s2, spkv_s2;
	logic [CW-1:0] idx_s1;
	logic [15:0]   rdata_s1;
	logic [31:0]   sq_s2;
	logic [SW-1:0] prod_s2;
	logic signed [16:0] dmean;
	logic signed [33:0] dmean_sq;
	logic [15:0]   absprev, trend_mag;

	// divider hookup
	logic          div_state, div_skip, div_start, div_done;
	logic [BW-1:0] div_dividend, div_quot;
	logic [CW-1:0] div_divisor, div_rem, t_new;

	// split into thirds
	logic [CW+15:0] third_prod;
	logic [CW-1:0]  third;

	// square-root step and result checks
	logic [31:0]   sq_try;
	logic          sq_ge, div_anom, spk_anom, calm_anom;
	logic [CW+7:0] spk_prod;

	// hold the store; register the read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	assign rd_en    = (state_q == ST_PASS) && (idx_q < n_q);
	assign dmean    = $signed({1'b0, rdata_s1}) - $signed({1'b0, mean_q});
	assign dmean_sq = dmean * dmean;
	assign absprev  = rdata_s1 >= prev_q ? rdata_s1 - prev_q : prev_q - rdata_s1;
	assign trend_mag = lastx_q >= first_q ? lastx_q - first_q : first_q - lastx_q;

	// pick divider operands per state
	always_comb begin
		div_state    = 1'b0;
		div_skip     = 1'b0;
		div_dividend = '0;
		div_divisor  = n_q;
		case (state_q)
			ST_MEAN: begin
				div_state    = 1'b1;
				div_dividend = BW'(sum_q);
			end
			ST_THIRD: begin
				// reciprocal multiply, no divider run
				div_skip = 1'b1;
			end
			ST_VAR: begin
				div_state    = 1'b1;
				div_dividend = acc_q;
			end
			ST_TREND: begin
				div_state    = 1'b1;
				div_skip     = n_q < CW'(2);
				div_dividend = BW'(trend_mag);
				div_divisor  = n_q - CW'(1);
			end
			ST_HEAD: begin
				div_state    = 1'b1;
				div_dividend = BW'(hs_q);
				div_divisor  = t_q;
			end
			ST_TAIL: begin
				div_state    = 1'b1;
				div_dividend = BW'(ts_q);
				div_divisor  = t_q;
			end
			ST_DIST: begin
				div_state    = 1'b1;
				div_skip     = len_q == '0;
				div_dividend = bsum_q;
				div_divisor  = len_q;
			end
			default: begin
				div_state = 1'b0;
			end
		endcase
	end

	assign div_start  = div_state && !launched_q && !div_skip;
	assign third_prod = (CW+16)'(n_q) * (CW+16)'(THIRD_RECIP);
	assign third      = CW'(third_prod >> THIRD_SHIFT);
	assign t_new      = (third == '0) ? CW'(1) : third;

	ssaf_div #(
		.DW(BW),
		.VW(CW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quot    (div_quot),
		.rem     (div_rem)
	);

	assign sq_try = sres_q + sbit_q;
	assign sq_ge  = sv_q >= sq_try;

	// anomaly conditions
	assign div_anom  = (len_q != '0) && ((dq_q > BW'(lim_sq_q)) ||
		((dq_q == BW'(lim_sq_q)) && dr_nz_q));
	assign spk_prod  = (CW+8)'(spk_q) * (CW+8)'(cfg.spike_divisor);
	assign spk_anom  = spk_prod > (CW+8)'(n_q);
	assign calm_anom = (mean_q < cfg.calm_mean_limit) &&
		(var_q > cfg.volatile_variance_limit);

	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign active  = state_q != ST_IDLE;

	// sequence the back end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			done       <= 1'b0;
		end else begin
			done   <= 1'b0;
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
			if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (div_start) begin
				launched_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						idx_q   <= '0;
						state_q <= ST_MEAN;
					end
				end
				ST_PASS: begin
					if (!rd_en && !vld_s1 && !vld_s2) begin
						state_q <= ST_VAR;
					end
				end
				ST_SQRT: begin
					if (sbit_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					if (div_skip || div_done) begin
						launched_q <= 1'b0;
						state_q    <= state_q + 4'd1;
					end
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			sq_s2   <= dmean_sq[31:0];
			prod_s2 <= SW'(absprev) * SW'(n_q);
			spkv_s2 <= idx_s1 != '0;
			prev_q  <= rdata_s1;
			if (idx_s1 == '0) begin
				first_q <= rdata_s1;
			end
			if (idx_s1 == n_q - CW'(1)) begin
				lastx_q <= rdata_s1;
			end
			if (idx_s1 < t_q) begin
				hs_q <= hs_q + SW'(rdata_s1);
			end
			if (idx_s1 >= tail_start_q) begin
				ts_q <= ts_q + SW'(rdata_s1);
			end
		end
		idx_s1 <= idx_q;
		if (vld_s2) begin
			acc_q <= acc_q + BW'(sq_s2);
			if (spkv_s2 && ((SW+1)'(prod_s2) > {sum_q, 1'b0})) begin
				spk_q <= spk_q + CW'(1);
			end
		end
		case (state_q)
			ST_IDLE: begin
				n_q      <= job_n;
				sum_q    <= job_sum;
				bsum_q   <= job_bsum;
				len_q    <= (32'(job_n) < 32'(cfg.baseline_length)) ? job_n :
					CW'(cfg.baseline_length);
				lim_sq_q <= cfg.divergence_limit * cfg.divergence_limit;
				acc_q    <= '0;
				spk_q    <= '0;
				hs_q     <= '0;
				ts_q     <= '0;
				trend_q  <= '0;
			end
			ST_MEAN: begin
				if (div_done) begin
					mean_q <= div_quot[15:0];
				end
			end
			ST_THIRD: begin
				t_q          <= t_new;
				tail_start_q <= n_q - t_new;
			end
			ST_VAR: begin
				if (div_done) begin
					var_q <= div_quot[31:0];
				end
			end
			ST_TREND: begin
				if (div_done) begin
					trend_q <= (lastx_q < first_q) ? -$signed({1'b0, div_quot[15:0]}) :
						$signed({1'b0, div_quot[15:0]});
				end
			end
			ST_HEAD: begin
				if (div_done) begin
					head_q <= div_quot[15:0];
				end
			end
			ST_TAIL: begin
				if (div_done) begin
					tail_q <= div_quot[15:0];
				end
			end
			ST_DIST: begin
				sres_q <= '0;
				sbit_q <= 32'h4000_0000;
				if (div_skip) begin
					dq_q    <= '0;
					dr_nz_q <= 1'b0;
					sv_q    <= '0;
				end else if (div_done) begin
					dq_q    <= div_quot;
					dr_nz_q <= div_rem != '0;
					sv_q    <= div_quot[31:0];
				end
			end
			ST_SQRT: begin
				if (sbit_q != '0) begin
					if (sq_ge) begin
						sv_q   <= sv_q - sq_try;
						sres_q <= (sres_q >> 1) + sbit_q;
					end else begin
						sres_q <= sres_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
				end else begin
					dist_q <= (dq_q[BW-1:32] != '0) ? 16'hFFFF : sres_q[15:0];
				end
			end
			ST_DONE: begin
				mean_value       <= mean_q;
				variance_value   <= var_q;
				trend_value      <= trend_q;
				spike_count      <= ((CW+10)'(spk_q) > (CW+10)'(1023)) ? 10'd1023 :
					spk_q[9:0] & 10'(((CW+10)'(1) << CW) - (CW+10)'(1));
				head_mean        <= head_q;
				tail_mean        <= tail_q;
				head_tail_gap    <= (head_q > tail_q) ? head_q - tail_q : tail_q - head_q;
				rms_distance     <= dist_q;
				anomaly          <= div_anom | spk_anom | calm_anom;
			end
			default: begin
				dr_nz_q <= dr_nz_q;
			end
		endcase
	end
endmodule

FILE: rtl/sequence_statistics_anomaly_flag.sv
// Top level of the sequence statistics and anomaly flag block.
// Depends on ssaf_pkg, ssaf_front, ssaf_queue, ssaf_back.
//
// Usage:
//   Drive sample, baseline_sample and last with start; a request is taken
//   at a clock edge where start is high and busy is low. Samples load at one
//   per cycle into the store while busy is low; samples beyond MaxElements
//   are dropped. A request with last set closes the sequence; busy then
//   rises and the back end runs: six divisions (the trend division is
//   skipped for fewer than two samples, the distance division when the
//   baseline window is empty), a split into thirds, one pass over the store
//   and a square root. The result shows for exactly one cycle with done
//   high; busy falls in that same cycle. Results cannot be held off by the
//   receiver.
//   Configuration: cfg_write, cfg_index, cfg_data, written while idle.
//   Reset clears the sums, the queue and the sequencer; registers take
//   their default values. The store needs no clearing.
module sequence_statistics_anomaly_flag #(
	parameter int MaxElements = ssaf_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [15:0]                       sample,
	input  logic [15:0]                       baseline_sample,
	input  logic                              last,
	input  logic                              cfg_write,
	input  logic [ssaf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssaf_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              done,
	output logic [15:0]                       mean_value,
	output logic [31:0]                       variance_value,
	output logic signed [16:0]                trend_value,
	output logic [9:0]                        spike_count,
	output logic [15:0]                       head_mean,
	output logic [15:0]                       tail_mean,
	output logic [15:0]                       head_tail_gap,
	output logic [15:0]                       rms_distance,
	output logic                              anomaly
);
	import ssaf_pkg::*;
	localparam int CW = $clog2(MaxElements + 1);
	localparam int AW = $clog2(MaxElements);
	localparam int SW = CW + 16;
	localparam int BW = CW + 32;
	localparam int JW = CW + SW + BW;

	cfg_t          cfg_q;
	logic          accept, mem_we, push, pop, q_not_empty, back_active;
	logic [AW-1:0] mem_addr;
	logic [15:0]   mem_wdata;
	logic [CW-1:0] f_n, b_n;
	logic [SW-1:0] f_sum, b_sum;
	logic [BW-1:0] f_bsum, b_bsum;
	logic [JW-1:0] q_rdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.baseline_length         <= RST_BASELINE_LENGTH;
			cfg_q.divergence_limit        <= RST_DIVERGENCE_LIMIT;
			cfg_q.calm_mean_limit         <= RST_CALM_MEAN_LIMIT;
			cfg_q.volatile_variance_limit <= RST_VOLATILE_LIMIT;
			cfg_q.spike_divisor           <= RST_SPIKE_DIVISOR;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BASELINE_LENGTH:  cfg_q.baseline_length <= cfg_data[10:0];
				REG_DIVERGENCE_LIMIT: cfg_q.divergence_limit <= cfg_data[15:0];
				REG_CALM_MEAN_LIMIT:  cfg_q.calm_mean_limit <= cfg_data[15:0];
				REG_VOLATILE_LIMIT:   cfg_q.volatile_variance_limit <= cfg_data;
				REG_SPIKE_DIVISOR:    cfg_q.spike_divisor <= cfg_data[7:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// hold requests off while a sequence is queued or being processed
	assign busy   = q_not_empty | back_active;
	assign accept = start & ~busy;

	ssaf_front #(
		.MaxElements(MaxElements)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.sample         (sample),
		.baseline_sample(baseline_sample),
		.last           (last),
		.baseline_length(cfg_q.baseline_length),
		.mem_we         (mem_we),
		.mem_addr       (mem_addr),
		.mem_wdata      (mem_wdata),
		.push           (push),
		.job_n          (f_n),
		.job_sum        (f_sum),
		.job_bsum       (f_bsum)
	);

	ssaf_queue #(
		.Width(JW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    ({f_n, f_sum, f_bsum}),
		.pop      (pop),
		.rdata    (q_rdata),
		.not_empty(q_not_empty)
	);

	assign {b_n, b_sum, b_bsum} = q_rdata;

	ssaf_back #(
		.MaxElements(MaxElements)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.mem_we          (mem_we),
		.mem_addr        (mem_addr),
		.mem_wdata       (mem_wdata),
		.job_valid       (q_not_empty),
		.job_n           (b_n),
		.job_sum         (b_sum),
		.job_bsum        (b_bsum),
		.job_pop         (pop),
		.active          (back_active),
		.done            (done),
		.mean_value      (mean_value),
		.variance_value  (variance_value),
		.trend_value     (trend_value),
		.spike_count     (spike_count),
		.head_mean       (head_mean),
		.tail_mean       (tail_mean),
		.head_tail_gap   (head_tail_gap),
		.rms_distance    (rms_distance),
		.anomaly         (anomaly)
	);
endmodule

FILE: rtl/ssaf_checker.sv
// Port-level checks for the sequence statistics block, bound to its top.
// Depends on sequence_statistics_anomaly_flag_defines.svh.
`include "sequence_statistics_anomaly_flag_defines.svh"

module ssaf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last,
	input logic        done,
	input logic [15:0] head_mean,
	input logic [15:0] tail_mean,
	input logic [15:0] head_tail_gap
);
	// a result only follows a busy period
	`SSAF_ASSERT_NOW(a_done_after_busy, done, $past(busy))
	// a closing request always starts processing
	`SSAF_ASSERT_NEXT(a_last_sets_busy, start && !busy && last, busy)
	// results never come back to back
	`SSAF_ASSERT_NEXT(a_done_single, done, !done)
	// gap matches the two means it is taken from
	`SSAF_ASSERT_NOW(a_gap_match, done, (head_mean >= tail_mean) ?
		(head_tail_gap == head_mean - tail_mean) : (head_tail_gap == tail_mean - head_mean))
endmodule

bind sequence_statistics_anomaly_flag ssaf_checker u_ssaf_checker (.*);
